FILE: src/ppi_pkg.sv
// Shared types and constants for the parallel port interface.
// No dependencies; imported by every module of the block.
`default_nettype none

package ppi_pkg;

	// Port select, taken from A9..A8
	localparam logic [1:0] PORT_A   = 2'd0;
	localparam logic [1:0] PORT_B   = 2'd1;
	localparam logic [1:0] PORT_C   = 2'd2;
	localparam logic [1:0] PORT_CTL = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_STRAP_BITS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRN_READY  = 8'd1;

	// Reset values
	localparam logic [7:0] DIR_RESET   = 8'h9B;
	localparam logic [7:0] STRAP_RESET = 8'h1E;

	// Address decode
	localparam int unsigned ADDR_SEL_BIT = 11;

	// Direction word bits, 1 = input
	localparam int unsigned DIR_A_IN   = 4;
	localparam int unsigned DIR_B_IN   = 1;
	localparam int unsigned DIR_CU_IN  = 3;
	localparam int unsigned DIR_CL_IN  = 0;
	localparam int unsigned CTL_MODE   = 7;

	// Packed stream widths
	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 32;

	typedef struct packed {
		logic        bus_ack;
		logic        io_request;
		logic        read_strobe;
		logic        write_strobe;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic        vsync;
		logic        tape_read_data;
		logic [7:0]  sound_bus_in;
	} ppi_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       read_valid;
		logic       sound_lines_driven;
		logic       bdir;
		logic       bc1;
		logic [3:0] keyboard_row;
		logic [7:0] sound_bus_out;
		logic       sound_bus_out_valid;
		logic       motor_out;
		logic       tape_write;
	} ppi_result_t;

	typedef struct packed {
		logic [7:0] latch_a;
		logic [7:0] latch_b;
		logic [7:0] latch_c;
		logic [7:0] direction_word;
		logic       motor_flag;
	} ppi_state_t;

	typedef struct packed {
		logic [7:0] strap_bits;
		logic       prn_ready;
	} ppi_cfg_t;

endpackage

`default_nettype wire

FILE: src/parallel_port_interface_8255.sv
// Parallel port interface, 8255 style, every mode behaving as mode 0.
// Depends on ppi_pkg, ppi_cfg and ppi_core.
//
// One request on the slave stream is one processor bus cycle. The block
// answers each request with exactly one result on the master stream: the
// sound-chip lines (BDIR, BC1, keyboard row, port A data) and the cassette
// motor and write-data wires as they stood before the access, plus the read
// byte on a selected read of A, B or C. I/O requests with A11 low select a
// port with A9..A8: A, B, C latches, or the control port (mode word or port C
// bit set/reset). A request is registered on entry, decoded in one pass of
// short logic and stored in the result register, so a new request is taken
// every cycle while the result register is free or drains. A held result
// back-pressures only through the input register, which still takes one more
// request while the result waits. Configuration writes (strap bits, printer
// ready) are always ready and take effect on the next edge; write them only
// while no request is in flight.
`default_nettype none

module parallel_port_interface_8255
	import ppi_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Slave stream. tdata from bit 0: bus_ack, io_request, read_strobe,
	// write_strobe, address[15:0], write_data[7:0], vsync, tape_read_data,
	// sound_bus_in[7:0], two zero pad bits
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// Master stream. tdata from bit 0: read_data[7:0], read_valid,
	// sound_lines_driven, bdir, bc1, keyboard_row[3:0], sound_bus_out[7:0],
	// sound_bus_out_valid, motor_out, tape_write, five zero pad bits
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// Configuration write channel
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [7:0]             cfg_data
);

	ppi_cfg_t    cfg;
	ppi_item_t   item_in;
	ppi_item_t   item_s1;
	logic        valid_s1;
	ppi_state_t  state_q;
	ppi_state_t  state_nxt;
	ppi_result_t res;
	ppi_result_t res_q;
	logic        out_valid_q;
	logic        advance;

	// Register file is always able to take a write
	assign cfg_ready = 1'b1;

	ppi_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_addr (cfg_addr),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	// Unpack the request, lowest field first
	always_comb begin
		item_in.bus_ack        = s_axis_tdata[0];
		item_in.io_request     = s_axis_tdata[1];
		item_in.read_strobe    = s_axis_tdata[2];
		item_in.write_strobe   = s_axis_tdata[3];
		item_in.address        = s_axis_tdata[19:4];
		item_in.write_data     = s_axis_tdata[27:20];
		item_in.vsync          = s_axis_tdata[28];
		item_in.tape_read_data = s_axis_tdata[29];
		item_in.sound_bus_in   = s_axis_tdata[37:30];
	end

	// Advance the input stage whenever the result register is free or drains
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	// Hold the request payload until it advances
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			item_s1 <= item_in;
	end

	ppi_core u_core (
		.item   (item_s1),
		.st     (state_q),
		.cfg    (cfg),
		.res    (res),
		.st_nxt (state_nxt)
	);

	// Port latches and direction word change only when a request completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.latch_a        <= 8'h00;
			state_q.latch_b        <= 8'h00;
			state_q.latch_c        <= 8'h00;
			state_q.direction_word <= DIR_RESET;
			state_q.motor_flag     <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register: load on advance, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, res_q.tape_write, res_q.motor_out,
		res_q.sound_bus_out_valid, res_q.sound_bus_out, res_q.keyboard_row,
		res_q.bc1, res_q.bdir, res_q.sound_lines_driven, res_q.read_valid,
		res_q.read_data};

endmodule

`default_nettype wire

FILE: src/ppi_cfg.sv
// Configuration register file: jumper straps and printer ready.
// Depends on ppi_pkg.
`default_nettype none

module ppi_cfg
	import ppi_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_addr,
	input  wire logic [7:0]           wr_data,
	output ppi_cfg_t                  cfg
);

	ppi_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strap_bits <= STRAP_RESET;
			cfg_q.prn_ready  <= 1'b0;
		end else if (wr_en) begin
			case (wr_addr)
				CFG_STRAP_BITS: cfg_q.strap_bits <= wr_data;
				CFG_PRN_READY:  cfg_q.prn_ready  <= wr_data[0];
				default:        ; // drop writes to unmapped indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: src/ppi_core.sv
// Bus access logic: line outputs, port read mux and latch update.
// Depends on ppi_pkg; purely combinational.
`default_nettype none

module ppi_core
	import ppi_pkg::*;
(
	input  wire ppi_item_t  item,
	input  wire ppi_state_t st,
	input  wire ppi_cfg_t   cfg,
	output ppi_result_t     res,
	output ppi_state_t      st_nxt
);

	logic       driven;
	logic       a_in, b_in, cu_in, cl_in;
	logic       sel;
	logic [1:0] port;
	logic [7:0] status_b;
	logic [7:0] read_c;
	logic [1:0] ctl;
	logic [7:0] bit_mask;
	logic [7:0] lc_bsr;

	assign driven = !item.bus_ack;
	assign a_in   = st.direction_word[DIR_A_IN];
	assign b_in   = st.direction_word[DIR_B_IN];
	assign cu_in  = st.direction_word[DIR_CU_IN];
	assign cl_in  = st.direction_word[DIR_CL_IN];
	assign sel    = item.io_request && !item.address[ADDR_SEL_BIT];
	assign port   = item.address[9:8];

	assign status_b = {item.tape_read_data, !cfg.prn_ready, 1'b1,
		cfg.strap_bits[4:1], item.vsync};

	// Upper half as input: control pair echoes, with 11 reading back as 10
	always_comb begin
		ctl    = (st.latch_c[7:6] == 2'b11) ? 2'b10 : st.latch_c[7:6];
		read_c = st.latch_c;
		if (cu_in)
			read_c[7:4] = {ctl, 1'b1, st.motor_flag};
		if (cl_in)
			read_c[3:0] = 4'hF;
	end

	assign bit_mask = 8'd1 << item.write_data[3:1];
	assign lc_bsr   = item.write_data[0] ? (st.latch_c | bit_mask)
		: (st.latch_c & ~bit_mask);

	// Lines published from the state before the access
	always_comb begin
		res.sound_lines_driven  = driven;
		res.bdir                = driven & st.latch_c[7];
		res.bc1                 = driven & st.latch_c[6];
		res.keyboard_row        = driven ? st.latch_c[3:0] : 4'h0;
		res.sound_bus_out_valid = driven & !a_in;
		res.sound_bus_out       = (driven && !a_in) ? st.latch_a : 8'h00;
		res.motor_out           = st.motor_flag;
		res.tape_write          = !cu_in & st.latch_c[5];
		res.read_data           = 8'h00;
		res.read_valid          = 1'b0;
		if (sel && item.read_strobe) begin
			case (port)
				PORT_A: begin
					res.read_data  = a_in ? item.sound_bus_in : st.latch_a;
					res.read_valid = 1'b1;
				end
				PORT_B: begin
					res.read_data  = b_in ? status_b : st.latch_b;
					res.read_valid = 1'b1;
				end
				PORT_C: begin
					res.read_data  = read_c;
					res.read_valid = 1'b1;
				end
				default: ; // control port is write-only, read floats
			endcase
		end
	end

	// Latch update; a read in the same cycle wins over the write
	always_comb begin
		st_nxt = st;
		if (sel && !item.read_strobe && item.write_strobe) begin
			case (port)
				PORT_A: st_nxt.latch_a = item.write_data;
				PORT_B: st_nxt.latch_b = item.write_data;
				PORT_C: begin
					st_nxt.latch_c = item.write_data;
					if (!cu_in)
						st_nxt.motor_flag = item.write_data[4];
				end
				default: begin
					if (item.write_data[CTL_MODE]) begin
						st_nxt.direction_word = item.write_data;
						st_nxt.latch_a        = 8'h00;
						st_nxt.latch_b        = 8'h00;
						st_nxt.latch_c        = 8'h00;
					end else begin
						st_nxt.latch_c = lc_bsr;
						if (!cu_in)
							st_nxt.motor_flag = lc_bsr[4];
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/ppi_checker.sv
// Port-level checks for the parallel port interface, bound to the top level.
// Depends on ppi_pkg and parallel_port_interface_8255.
`default_nettype none

module ppi_checker
	import ppi_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tready,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result holds its valid and payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// With the result register empty the input side must be open
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result register");

	// Undriven sound lines read as zero
	a_lines_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[9] |-> m_axis_tdata[24:10] == 15'd0)
		else $error("sound lines active while not driven");

	// No read byte without read_valid
	a_read_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'h00)
		else $error("read data without read_valid");

	// Port A data valid only while the lines are driven
	a_bus_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[9])
		else $error("port A valid while lines undriven");

endmodule

bind parallel_port_interface_8255 ppi_checker u_ppi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: sim/tb.sv
// Self-checking bench for parallel_port_interface_8255: stream-driven bus cycles,
// a cycle-level model of the 8255 ports and a field-by-field result check.
// Depends on ppi_pkg and the RTL under src only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ppi_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_addr;
	logic [7:0]             cfg_data;

	parallel_port_interface_8255 u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	// Directed script: a bus cycle, and for the rows whose answer is obvious
	// (right after reset, status extremes, floating reads) the result typed in.
	typedef struct {
		ppi_item_t   cyc;
		bit          fixed;
		ppi_result_t want;
	} script_row_t;

	script_row_t script[$];
	ppi_result_t bus_results_due[$];

	// Port state as the processor sees it, plus the jumper configuration
	logic [7:0] port_a_latch, port_b_latch, port_c_latch, dir_word;
	logic       motor_latch;
	logic [7:0] straps;
	logic       printer_rdy;

	int errors;
	int sent;
	int directed_sent;
	int results;
	int cfg_writes;
	int mode_words;
	int phase_items;
	int phase;
	int send_idle;
	int rcv_idle;
	bit stall_done;
	int k;
	ppi_result_t seen;
	ppi_result_t want;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the handshakes hang
	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [IN_TDATA_W-1:0] pack_cycle(input ppi_item_t c);
		return {2'b00, c.sound_bus_in, c.tape_read_data, c.vsync, c.write_data, c.address,
			c.write_strobe, c.read_strobe, c.io_request, c.bus_ack};
	endfunction

	function automatic ppi_result_t unpack_result(input logic [OUT_TDATA_W-1:0] t);
		ppi_result_t r;
		r.read_data           = t[7:0];
		r.read_valid          = t[8];
		r.sound_lines_driven  = t[9];
		r.bdir                = t[10];
		r.bc1                 = t[11];
		r.keyboard_row        = t[15:12];
		r.sound_bus_out       = t[23:16];
		r.sound_bus_out_valid = t[24];
		r.motor_out           = t[25];
		r.tape_write          = t[26];
		return r;
	endfunction

	function automatic ppi_item_t cyc(input logic ack, input logic iorq, input logic rd,
			input logic wr, input logic [15:0] addr, input logic [7:0] wdata,
			input logic vs, input logic tape, input logic [7:0] snd);
		ppi_item_t c;
		c.bus_ack        = ack;
		c.io_request     = iorq;
		c.read_strobe    = rd;
		c.write_strobe   = wr;
		c.address        = addr;
		c.write_data     = wdata;
		c.vsync          = vs;
		c.tape_read_data = tape;
		c.sound_bus_in   = snd;
		return c;
	endfunction

	function automatic ppi_result_t res(input logic [7:0] rd, input logic rv, input logic drv,
			input logic bd, input logic b1, input logic [3:0] row, input logic [7:0] sbo,
			input logic sbov, input logic mot, input logic tw);
		ppi_result_t r;
		r.read_data           = rd;
		r.read_valid          = rv;
		r.sound_lines_driven  = drv;
		r.bdir                = bd;
		r.bc1                 = b1;
		r.keyboard_row        = row;
		r.sound_bus_out       = sbo;
		r.sound_bus_out_valid = sbov;
		r.motor_out           = mot;
		r.tape_write          = tw;
		return r;
	endfunction

	function automatic void add_row(input ppi_item_t c, input bit fixed, input ppi_result_t w);
		script_row_t row;
		row.cyc   = c;
		row.fixed = fixed;
		row.want  = w;
		script.push_back(row);
	endfunction

	// Copy port C bit 4 into the motor relay, but only while the upper half drives
	function automatic void sense_motor();
		if (!dir_word[DIR_CU_IN])
			motor_latch = port_c_latch[4];
	endfunction

	// One bus cycle: publish the lines from the old latches, then serve the access
	function automatic ppi_result_t bus_cycle(input ppi_item_t c);
		ppi_result_t r;
		logic [1:0]  port;
		logic [7:0]  pc;
		logic [1:0]  ctl;
		r = '0;
		r.sound_lines_driven = !c.bus_ack;
		if (!c.bus_ack) begin
			r.bdir         = port_c_latch[7];
			r.bc1          = port_c_latch[6];
			r.keyboard_row = port_c_latch[3:0];
			if (!dir_word[DIR_A_IN]) begin
				r.sound_bus_out       = port_a_latch;
				r.sound_bus_out_valid = 1'b1;
			end
		end
		r.motor_out  = motor_latch;
		r.tape_write = !dir_word[DIR_CU_IN] && port_c_latch[5];

		if (c.io_request && !c.address[ADDR_SEL_BIT]) begin
			port = c.address[9:8];
			if (c.read_strobe) begin
				case (port)
					PORT_A: begin
						r.read_data  = dir_word[DIR_A_IN] ? c.sound_bus_in : port_a_latch;
						r.read_valid = 1'b1;
					end
					PORT_B: begin
						r.read_data  = dir_word[DIR_B_IN]
							? {c.tape_read_data, !printer_rdy, 1'b1, straps[4:1], c.vsync}
							: port_b_latch;
						r.read_valid = 1'b1;
					end
					PORT_C: begin
						pc = port_c_latch;
						if (dir_word[DIR_CU_IN]) begin
							// BDIR/BC1 echo, with both set reading back as BDIR alone
							ctl = (port_c_latch[7:6] == 2'b11) ? 2'b10 : port_c_latch[7:6];
							pc  = {ctl, 1'b1, motor_latch, port_c_latch[3:0]};
						end
						if (dir_word[DIR_CL_IN])
							pc[3:0] = 4'hF;
						r.read_data  = pc;
						r.read_valid = 1'b1;
					end
					default: ;
				endcase
			end else if (c.write_strobe) begin
				case (port)
					PORT_A: port_a_latch = c.write_data;
					PORT_B: port_b_latch = c.write_data;
					PORT_C: begin
						port_c_latch = c.write_data;
						sense_motor();
					end
					default: begin
						if (c.write_data[CTL_MODE]) begin
							// Mode word: new directions, latches cleared, motor kept
							dir_word     = c.write_data;
							port_a_latch = '0;
							port_b_latch = '0;
							port_c_latch = '0;
							mode_words++;
						end else begin
							port_c_latch[c.write_data[3:1]] = c.write_data[0];
							sense_motor();
						end
					end
				endcase
			end
		end
		return r;
	endfunction

	// Mostly well-formed selected accesses; a tenth is raw noise on every field
	function automatic ppi_item_t random_cycle();
		ppi_item_t c;
		int unsigned pick;
		pick             = $urandom_range(99);
		c.bus_ack        = ($urandom_range(7) == 0);
		c.io_request     = 1'($urandom);
		c.read_strobe    = 1'($urandom);
		c.write_strobe   = 1'($urandom);
		c.address        = 16'($urandom);
		c.write_data     = 8'($urandom);
		c.vsync          = 1'($urandom);
		c.tape_read_data = 1'($urandom);
		c.sound_bus_in   = 8'($urandom);
		if (pick >= 10) begin
			c.io_request             = 1'b1;
			c.address[ADDR_SEL_BIT]  = 1'b0;
			if (pick < 50) begin
				c.read_strobe = 1'b1;
			end else begin
				c.read_strobe  = 1'b0;
				c.write_strobe = 1'b1;
				if (pick >= 92) begin
					c.address[9:8]         = PORT_CTL;
					c.write_data[CTL_MODE] = 1'b1;
				end
			end
		end
		return c;
	endfunction

	// Offer one request, with random gaps ahead of it, and hold it until taken
	task automatic send_request(input ppi_item_t c, input bit fixed, input ppi_result_t w);
		ppi_result_t p;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pack_cycle(c);
		do @(posedge clk); while (!s_axis_tready);
		p = bus_cycle(c);
		bus_results_due.push_back(fixed ? w : p);
		sent++;
		phase_items++;
	endtask

	// Write one register once the block has drained and settled
	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		while (bus_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_STRAP_BITS: straps = val;
			CFG_PRN_READY:  printer_rdy = val[0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [7:0] w, input logic [7:0] g);
		if (w !== g) begin
			errors++;
			$display("%0t ns: %s expected %0h got %0h", $time, name, w, g);
		end
	endtask

	// Receiver: random stalls per phase, and once a long hold-off so the block backs up
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (phase == 2 && !stall_done && phase_items >= 40) begin
				m_axis_tready <= 1'b0;
				repeat (60) @(negedge clk);
				stall_done = 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rcv_idle);
			end
		end
	end

	// Compare every accepted result with the oldest one due
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = unpack_result(m_axis_tdata);
			if (bus_results_due.size() == 0) begin
				errors++;
				$display("%0t ns: result %0h with none expected, expected nothing got %0h",
					$time, m_axis_tdata, m_axis_tdata);
			end else begin
				want = bus_results_due.pop_front();
				results++;
				check_field("read_data", want.read_data, seen.read_data);
				check_field("read_valid", 8'(want.read_valid), 8'(seen.read_valid));
				check_field("sound_lines_driven", 8'(want.sound_lines_driven),
					8'(seen.sound_lines_driven));
				check_field("bdir", 8'(want.bdir), 8'(seen.bdir));
				check_field("bc1", 8'(want.bc1), 8'(seen.bc1));
				check_field("keyboard_row", 8'(want.keyboard_row), 8'(seen.keyboard_row));
				check_field("sound_bus_out", want.sound_bus_out, seen.sound_bus_out);
				check_field("sound_bus_out_valid", 8'(want.sound_bus_out_valid),
					8'(seen.sound_bus_out_valid));
				check_field("motor_out", 8'(want.motor_out), 8'(seen.motor_out));
				check_field("tape_write", 8'(want.tape_write), 8'(seen.tape_write));
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_addr      = '0;
		cfg_data      = '0;
		phase         = 0;
		send_idle     = 27;
		rcv_idle      = 86;
		stall_done    = 1'b0;

		// Model state right after reset
		port_a_latch = '0;
		port_b_latch = '0;
		port_c_latch = '0;
		dir_word     = DIR_RESET;
		motor_latch  = 1'b0;
		straps       = STRAP_RESET;
		printer_rdy  = 1'b0;

		// Reset state: nothing selected, all ports input
		add_row(cyc(0, 0, 0, 0, 16'h0000, 8'h00, 0, 0, 8'h00), 1,
			res(8'h00, 0, 1, 0, 0, 4'h0, 8'h00, 0, 0, 0));
		// Lines released; port A reads the sound bus
		add_row(cyc(1, 1, 1, 0, 16'h0000, 8'h00, 0, 0, 8'hA5), 1,
			res(8'hA5, 1, 0, 0, 0, 4'h0, 8'h00, 0, 0, 0));
		// Port B status with every live bit high, then low
		add_row(cyc(0, 1, 1, 0, 16'h0100, 8'h00, 1, 1, 8'h00), 1,
			res(8'hFF, 1, 1, 0, 0, 4'h0, 8'h00, 0, 0, 0));
		add_row(cyc(0, 1, 1, 0, 16'hF5FF, 8'hFF, 0, 0, 8'hFF), 1,
			res(8'h7E, 1, 1, 0, 0, 4'h0, 8'h00, 0, 0, 0));
		// Port C with both halves input
		add_row(cyc(0, 1, 1, 0, 16'h0200, 8'h00, 0, 0, 8'h00), 1,
			res(8'h2F, 1, 1, 0, 0, 4'h0, 8'h00, 0, 0, 0));
		// Control port read floats
		add_row(cyc(0, 1, 1, 0, 16'h0300, 8'h00, 0, 0, 8'h00), 1,
			res(8'h00, 0, 1, 0, 0, 4'h0, 8'h00, 0, 0, 0));
		// A11 high deselects, for a read and for a mode word
		add_row(cyc(0, 1, 1, 0, 16'hFFFF, 8'hFF, 1, 1, 8'hFF), 1,
			res(8'h00, 0, 1, 0, 0, 4'h0, 8'h00, 0, 0, 0));
		add_row(cyc(0, 1, 0, 1, 16'h0B00, 8'h80, 0, 0, 8'h00), 1,
			res(8'h00, 0, 1, 0, 0, 4'h0, 8'h00, 0, 0, 0));
		// Write strobe outside an I/O cycle
		add_row(cyc(0, 0, 0, 1, 16'h0300, 8'h80, 0, 0, 8'h00), 1,
			res(8'h00, 0, 1, 0, 0, 4'h0, 8'h00, 0, 0, 0));
		// From here the model decides: all outputs, fill every latch
		add_row(cyc(0, 1, 0, 1, 16'h0300, 8'h80, 0, 0, 8'h00), 0, '0);
		add_row(cyc(0, 1, 0, 1, 16'h0000, 8'hFF, 0, 0, 8'h00), 0, '0);
		add_row(cyc(0, 1, 0, 1, 16'h0100, 8'h00, 0, 0, 8'h00), 0, '0);
		add_row(cyc(0, 1, 0, 1, 16'h0200, 8'hFF, 0, 0, 8'h00), 0, '0);
		add_row(cyc(1, 1, 1, 0, 16'h0000, 8'h00, 1, 1, 8'h3C), 0, '0);
		add_row(cyc(0, 1, 1, 0, 16'h0100, 8'h00, 1, 1, 8'h00), 0, '0);
		add_row(cyc(0, 1, 1, 0, 16'h0200, 8'h00, 0, 0, 8'h00), 0, '0);
		// Read and write together: the read wins
		add_row(cyc(0, 1, 1, 1, 16'h0000, 8'h12, 0, 0, 8'h00), 0, '0);
		// Bit set/reset on port C
		add_row(cyc(0, 1, 0, 1, 16'h0300, 8'h0F, 0, 0, 8'h00), 0, '0);
		add_row(cyc(0, 1, 0, 1, 16'h0300, 8'h00, 0, 0, 8'h00), 0, '0);
		// Back to all inputs: motor survives, BDIR+BC1 echo as BDIR
		add_row(cyc(0, 1, 0, 1, 16'h0300, 8'h9B, 0, 0, 8'h00), 0, '0);
		add_row(cyc(0, 1, 0, 1, 16'h0300, 8'h0F, 0, 0, 8'h00), 0, '0);
		add_row(cyc(0, 1, 0, 1, 16'h0300, 8'h0D, 0, 0, 8'h00), 0, '0);
		add_row(cyc(0, 1, 1, 0, 16'h0200, 8'h00, 0, 0, 8'h00), 0, '0);
		// Lower C input only, then upper C input only
		add_row(cyc(0, 1, 0, 1, 16'h0300, 8'h81, 0, 0, 8'h00), 0, '0);
		add_row(cyc(0, 1, 0, 1, 16'h0200, 8'hE5, 0, 0, 8'h00), 0, '0);
		add_row(cyc(0, 1, 1, 0, 16'h0200, 8'h00, 0, 0, 8'h00), 0, '0);
		add_row(cyc(0, 1, 0, 1, 16'h0300, 8'h08, 0, 0, 8'h00), 0, '0);
		add_row(cyc(0, 1, 0, 1, 16'h0300, 8'h88, 0, 0, 8'h00), 0, '0);
		add_row(cyc(0, 1, 1, 0, 16'h0200, 8'h00, 0, 0, 8'h00), 0, '0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			send_request(script[i].cyc, script[i].fixed, script[i].want);
		directed_sent = sent;

		// Three pacing phases, each with its own jumper setting
		for (int ph = 0; ph < 3; ph++) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			case (ph)
				0: begin
					write_cfg(CFG_STRAP_BITS, 8'hFF);
					write_cfg(CFG_PRN_READY, 8'h01);
				end
				1: begin
					send_idle = 86;
					rcv_idle  = 27;
					write_cfg(CFG_STRAP_BITS, 8'h00);
					write_cfg(CFG_PRN_READY, 8'h00);
				end
				default: begin
					send_idle = 0;
					rcv_idle  = 0;
					write_cfg(CFG_STRAP_BITS, 8'($urandom));
					write_cfg(CFG_PRN_READY, 8'h01);
				end
			endcase
			phase_items = 0;
			phase       = ph;
			repeat (607)
				send_request(random_cycle(), 1'b0, '0);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// Drain, then let the pipeline settle
		for (k = 0; k < 20000 && bus_results_due.size() != 0; k++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (bus_results_due.size() != 0) begin
			errors += bus_results_due.size();
			$display("%0t ns: results outstanding, expected 0 got %0d", $time,
				bus_results_due.size());
		end

		$display("Ran %0d bus cycles (%0d scripted), checked %0d results, %0d mode words,",
			sent, directed_sent, results, mode_words);
		$display("%0d jumper writes over three pacing phases with one long output stall.",
			cfg_writes);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
